// ===== hdl/lemsq_pkg.sv =====
// Package for the lamp effect mode sequencer: beat structs, codes, timing
// constants and the controller/datapath command and status structs.
// Depends on nothing; every other file of the block imports it.
package lemsq_pkg;

  localparam int DIV_W       = 32;
  localparam int DVS_W       = 10;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_CYCLES  = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
  localparam int LEVEL_W     = 8;
  localparam int MUL_W       = DVS_W + LEVEL_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [DIV_W-1:0] BREATHE_MS   = 32'd10000;
  localparam logic [DIV_W-1:0] VIB_DELAY_MS = 32'd500;

  localparam logic [DVS_W-1:0] BLINK_PERIOD     = 10'd200;
  localparam logic [DVS_W-1:0] BLINK_MID        = 10'd100;
  localparam logic [DVS_W-1:0] BLINK_FALL_START = 10'd101;
  localparam logic [DVS_W-1:0] BLINK_FALL_SPAN  = 10'd99;
  localparam logic [DVS_W-1:0] PERIOD_MAX       = 10'd1000;
  // The period shrinks by 800 ms over 10 s, which is 2t/25.
  localparam logic [DVS_W-1:0] PERIOD_SLOPE_DIV = 10'd25;

  localparam logic [7:0] CMD_SAMPLE = 8'hFF;

  localparam logic [LEVEL_W-1:0] PEAK_RESET = 8'd177;

  typedef enum logic [1:0] {
    MODE_BLINK   = 2'd0,
    MODE_OFF     = 2'd1,
    MODE_BREATHE = 2'd2,
    MODE_IDLE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SND_NONE = 2'd0,
    SND_STOP = 2'd1,
    SND_PLAY = 2'd2
  } sound_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_LEVEL     = 1'b0,
    REG_PLAYER_PRESENT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_BLINK,
    JOB_BREATHE
  } job_e;

  typedef enum logic [2:0] {
    OP_BLINK_MOD,
    OP_BLINK_SCALE,
    OP_BREATHE_PERIOD,
    OP_BREATHE_MOD,
    OP_BREATHE_SCALE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLINK_MOD,
    ST_BLINK_SCALE,
    ST_BREATHE_PERIOD,
    ST_BREATHE_MOD,
    ST_BREATHE_SCALE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  buttons;
    logic        command_valid;
    logic [7:0]  command_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] lamp_level;
    logic       vibration_on;
    logic [1:0] sound_command;
    logic [1:0] active_mode;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    op_e  div_op;
    logic set_lamp;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    job_e job;
    logic div_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    mode_e      mode;
    logic       pending;
    logic [7:0] remembered;
  } pat_state_t;

  function automatic pat_state_t apply_pattern(pat_state_t s, logic [7:0] pattern,
                                               logic forced);
    pat_state_t r;
    r = s;
    if (forced) begin
      r.remembered = 8'd0;
    end
    if (r.remembered != pattern) begin
      r.remembered = pattern;
      priority if (pattern[0]) begin
        r.mode    = MODE_BLINK;
        r.pending = 1'b1;
      end else if (pattern[1]) begin
        r.mode    = MODE_OFF;
        r.pending = 1'b1;
      end else if (pattern[2]) begin
        r.mode    = MODE_BREATHE;
        r.pending = 1'b1;
      end else if (pattern[3]) begin
        r.mode    = MODE_IDLE;
        r.pending = 1'b1;
      end else begin
        r.mode = s.mode;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/lemsq_div.sv =====
// Iterative restoring divider, several quotient bits per cycle.
// Unsigned 32-bit dividend by a narrow divisor; depends on lemsq_pkg.
module lemsq_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lemsq_pkg::DIV_W-1:0] dividend_i,
  input  logic [lemsq_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [lemsq_pkg::DIV_W-1:0] quot_o,
  output logic [lemsq_pkg::DVS_W-1:0] rem_o
);
  import lemsq_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(DIV_CYCLES - 1);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [DIV_W-1:0]     quot_q, quot_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q;

  always_comb begin
    logic [DVS_W:0] trial;
    logic           qbit;
    quot_d = quot_q;
    rem_d  = rem_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_d, quot_d[DIV_W-1]};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(trial - {1'b0, dvs_q});
        qbit  = 1'b1;
      end else begin
        rem_d = trial[DVS_W-1:0];
        qbit  = 1'b0;
      end
      quot_d = {quot_d[DIV_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/lemsq_ctrl.sv =====
// Controller of the sequencer: accepts a beat, sequences the divisions of
// the blink or breathe effect and hands the result to the output register.
// Depends on lemsq_pkg.
module lemsq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lemsq_pkg::stat_t stat_i,
  output lemsq_pkg::ctrl_t ctrl_o
);
  import lemsq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.job)
            JOB_BLINK:   state_d = ST_BLINK_MOD;
            JOB_BREATHE: state_d = ST_BREATHE_PERIOD;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_BLINK_MOD:      if (stat_i.div_done) state_d = ST_BLINK_SCALE;
      ST_BLINK_SCALE:    if (stat_i.div_done) state_d = ST_DONE;
      ST_BREATHE_PERIOD: if (stat_i.div_done) state_d = ST_BREATHE_MOD;
      ST_BREATHE_MOD:    if (stat_i.div_done) state_d = ST_BREATHE_SCALE;
      ST_BREATHE_SCALE:  if (stat_i.div_done) state_d = ST_DONE;
      ST_DONE:           if (stat_i.out_free) state_d = ST_IDLE;
      default:           state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '{accept: 1'b0, div_start: 1'b0, div_op: OP_BLINK_MOD,
                   set_lamp: 1'b0, load_out: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
        if (in_valid_i && stat_i.job == JOB_BLINK) begin
          ctrl_o.div_start = 1'b1;
          ctrl_o.div_op    = OP_BLINK_MOD;
        end else if (in_valid_i && stat_i.job == JOB_BREATHE) begin
          ctrl_o.div_start = 1'b1;
          ctrl_o.div_op    = OP_BREATHE_PERIOD;
        end
      end
      ST_BLINK_MOD: begin
        ctrl_o.div_start = stat_i.div_done;
        ctrl_o.div_op    = OP_BLINK_SCALE;
      end
      ST_BREATHE_PERIOD: begin
        ctrl_o.div_start = stat_i.div_done;
        ctrl_o.div_op    = OP_BREATHE_MOD;
      end
      ST_BREATHE_MOD: begin
        ctrl_o.div_start = stat_i.div_done;
        ctrl_o.div_op    = OP_BREATHE_SCALE;
      end
      ST_BLINK_SCALE, ST_BREATHE_SCALE: begin
        ctrl_o.set_lamp = stat_i.div_done;
      end
      ST_DONE: begin
        ctrl_o.load_out = stat_i.out_free;
      end
      default: begin
        ctrl_o.load_out = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/lemsq_dp.sv =====
// Datapath of the sequencer: mode and effect state, configuration registers,
// divider operand selection with the level multiplier, and the output register.
// Depends on lemsq_pkg and lemsq_div.
module lemsq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lemsq_pkg::in_beat_t             in_data_i,
  input  logic                            cfg_we_i,
  input  logic [lemsq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lemsq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output lemsq_pkg::out_beat_t            out_data_o,
  input  lemsq_pkg::ctrl_t                ctrl_i,
  output lemsq_pkg::stat_t                stat_o
);
  import lemsq_pkg::*;

  logic [LEVEL_W-1:0] peak_q;
  logic               player_q;

  mode_e              mode_q, mode_d;
  logic               pending_q, pending_d;
  logic [7:0]         remembered_q, remembered_d;
  logic               steady_q, steady_d;
  logic [DIV_W-1:0]   start_q, start_d;
  logic [LEVEL_W-1:0] lamp_q, lamp_d;
  logic               vib_q, vib_d;
  sound_e             sound_q, sound_d;

  logic [DIV_W-1:0]   x_q;
  logic [DVS_W-1:0]   period_q;
  logic               fall_q;

  logic               out_valid_q;
  out_beat_t          out_data_q;

  pat_state_t         pat0, pat1, pat2;
  logic [DIV_W-1:0]   elapsed;
  job_e               job;

  logic [DIV_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [DVS_W-1:0]   div_rem;
  logic [DVS_W-1:0]   mul_a;
  logic [MUL_W-1:0]   prod;
  logic [DVS_W-1:0]   period_w;
  logic [DVS_W-1:0]   half;
  logic               fall_w;

  always_comb begin
    pat0 = '{mode: mode_q, pending: pending_q, remembered: remembered_q};
    pat1 = pat0;
    if (in_data_i.command_valid) begin
      if (in_data_i.command_value == CMD_SAMPLE) begin
        pat1 = apply_pattern(pat0, {4'd0, in_data_i.buttons}, 1'b0);
      end else begin
        pat1 = apply_pattern(pat0, in_data_i.command_value, 1'b1);
      end
    end
    pat2 = apply_pattern(pat1, {4'd0, in_data_i.buttons}, 1'b0);
  end

  assign elapsed = in_data_i.now_ms - start_q;

  always_comb begin
    job = JOB_NONE;
    if (!pat2.pending) begin
      if (pat2.mode == MODE_BLINK && !steady_q) begin
        job = JOB_BLINK;
      end else if (pat2.mode == MODE_BREATHE && elapsed < BREATHE_MS) begin
        job = JOB_BREATHE;
      end
    end
  end

  always_comb begin
    mode_d       = mode_q;
    pending_d    = pending_q;
    remembered_d = remembered_q;
    steady_d     = steady_q;
    start_d      = start_q;
    lamp_d       = lamp_q;
    vib_d        = vib_q;
    sound_d      = sound_q;
    if (ctrl_i.accept) begin
      mode_d       = pat2.mode;
      pending_d    = 1'b0;
      remembered_d = pat2.remembered;
      sound_d      = SND_NONE;
      if (pat2.pending) begin
        unique case (pat2.mode)
          MODE_BLINK: begin
            start_d  = in_data_i.now_ms;
            steady_d = !steady_q;
            if (!steady_q) begin
              lamp_d = peak_q;
            end
            vib_d   = 1'b0;
            sound_d = SND_STOP;
          end
          MODE_OFF: begin
            steady_d = 1'b0;
            lamp_d   = '0;
            vib_d    = 1'b0;
            sound_d  = SND_STOP;
          end
          MODE_BREATHE: begin
            steady_d = 1'b0;
            start_d  = in_data_i.now_ms;
            vib_d    = 1'b1;
            sound_d  = SND_PLAY;
          end
          default: begin
            sound_d = SND_NONE;
          end
        endcase
      end else if (pat2.mode == MODE_BREATHE) begin
        if (elapsed > VIB_DELAY_MS) begin
          vib_d = 1'b1;
        end
        if (elapsed >= BREATHE_MS) begin
          lamp_d  = '0;
          vib_d   = 1'b0;
          sound_d = SND_STOP;
        end
      end
    end else if (ctrl_i.set_lamp) begin
      lamp_d = fall_q ? peak_q - div_quot[LEVEL_W-1:0] : div_quot[LEVEL_W-1:0];
    end
  end

  assign period_w = PERIOD_MAX - div_quot[DVS_W-1:0];
  assign half     = {1'b0, period_q[DVS_W-1:1]};
  assign prod     = MUL_W'(mul_a) * MUL_W'(peak_q);

  always_comb begin
    div_dvd = in_data_i.now_ms;
    div_dvs = BLINK_PERIOD;
    mul_a   = div_rem;
    fall_w  = 1'b0;
    unique case (ctrl_i.div_op)
      OP_BLINK_MOD: begin
        div_dvd = in_data_i.now_ms;
        div_dvs = BLINK_PERIOD;
      end
      OP_BLINK_SCALE: begin
        if (div_rem <= BLINK_MID) begin
          mul_a   = div_rem;
          div_dvs = BLINK_MID;
        end else begin
          mul_a   = div_rem - BLINK_FALL_START;
          div_dvs = BLINK_FALL_SPAN;
          fall_w  = 1'b1;
        end
        div_dvd = DIV_W'(prod);
      end
      OP_BREATHE_PERIOD: begin
        div_dvd = {elapsed[DIV_W-2:0], 1'b0};
        div_dvs = PERIOD_SLOPE_DIV;
      end
      OP_BREATHE_MOD: begin
        div_dvd = x_q;
        div_dvs = period_w;
      end
      OP_BREATHE_SCALE: begin
        if (div_rem < half) begin
          mul_a   = div_rem;
          div_dvs = half;
        end else begin
          mul_a   = div_rem - half;
          div_dvs = period_q - half;
          fall_w  = 1'b1;
        end
        div_dvd = DIV_W'(prod);
      end
      default: begin
        div_dvd = in_data_i.now_ms;
      end
    endcase
  end

  lemsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q       <= PEAK_RESET;
      player_q     <= 1'b0;
      mode_q       <= MODE_BLINK;
      pending_q    <= 1'b1;
      remembered_q <= '0;
      steady_q     <= 1'b0;
      start_q      <= '0;
      lamp_q       <= '0;
      vib_q        <= 1'b0;
      sound_q      <= SND_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PEAK_LEVEL:     peak_q   <= cfg_wdata_i;
          REG_PLAYER_PRESENT: player_q <= cfg_wdata_i[0];
        endcase
      end
      mode_q       <= mode_d;
      pending_q    <= pending_d;
      remembered_q <= remembered_d;
      steady_q     <= steady_d;
      start_q      <= start_d;
      lamp_q       <= lamp_d;
      vib_q        <= vib_d;
      sound_q      <= sound_d;
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      x_q <= elapsed;
    end
    if (ctrl_i.div_start) begin
      fall_q <= fall_w;
    end
    if (ctrl_i.div_start && ctrl_i.div_op == OP_BREATHE_MOD) begin
      period_q <= period_w;
    end
    if (ctrl_i.load_out) begin
      out_data_q.lamp_level    <= lamp_q;
      out_data_q.vibration_on  <= vib_q;
      out_data_q.sound_command <= player_q ? sound_q : SND_NONE;
      out_data_q.active_mode   <= mode_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign stat_o.job      = job;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== hdl/lamp_effect_mode_sequencer.sv =====
// Top level of the lamp effect mode sequencer: controller, datapath and the
// configuration port. Depends on lemsq_pkg, lemsq_ctrl and lemsq_dp.
//
// Usage: each input beat is one tick (timestamp, button bits, optional
// forced command). Every accepted beat yields exactly one output beat with
// the lamp level, vibration drive, a one-tick sound command and the mode.
// Both channels are valid/ready; configuration is a plain write port
// (index 0 peak level, index 1 player present) used while the block is idle.
// Ticks that only update state go straight to the output register. A blink
// tick runs two divisions and a breathing tick three, one after the other,
// on the shared divider, which retires four quotient bits per cycle.
// One beat is processed at a time; in_ready_o is high whenever the
// sequencer has no beat in flight, also while a finished result waits in
// the output register. If the receiver stalls, the next beat is computed
// and then held until the output register frees up. Reset returns the
// mode and effect state, the controller state and both configuration
// registers to their defaults; no output beat is pending after reset.
module lamp_effect_mode_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lemsq_pkg::in_beat_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lemsq_pkg::out_beat_t            out_data_o,
  input  logic                            cfg_we_i,
  input  logic [lemsq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lemsq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lemsq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  lemsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lemsq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lamp_effect_mode_sequencer: directed and random
// ticks against a tick-accurate model of the lamp effects, random idling on
// both channels. Depends on lemsq_pkg and the RTL of the block.
module tb_top;
  import lemsq_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;
  logic      cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lamp_effect_mode_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  out_beat_t   lamp_expect_q[$];
  int unsigned failures = 0;
  bit          send_steady = 1'b0;
  bit          sink_steady = 1'b0;

  int unsigned peak_cfg;
  bit          player_cfg;
  mode_e       cur_mode;
  bit          entry_armed;
  logic [7:0]  last_pattern;
  bit          steady_lit;
  logic [31:0] effect_t0;
  int unsigned lamp_held;
  bit          vib_held;

  function automatic void model_reset();
    peak_cfg     = PEAK_RESET;
    player_cfg   = 1'b0;
    cur_mode     = MODE_BLINK;
    entry_armed  = 1'b1;
    last_pattern = 8'd0;
    steady_lit   = 1'b0;
    effect_t0    = 32'd0;
    lamp_held    = 0;
    vib_held     = 1'b0;
  endfunction

  function automatic void latch_pattern(logic [7:0] pat, bit forced);
    if (forced) begin
      last_pattern = 8'd0;
    end
    if (last_pattern != pat) begin
      last_pattern = pat;
      if (pat[0]) begin
        cur_mode    = MODE_BLINK;
        entry_armed = 1'b1;
      end else if (pat[1]) begin
        cur_mode    = MODE_OFF;
        entry_armed = 1'b1;
      end else if (pat[2]) begin
        cur_mode    = MODE_BREATHE;
        entry_armed = 1'b1;
      end else if (pat[3]) begin
        cur_mode    = MODE_IDLE;
        entry_armed = 1'b1;
      end
    end
  endfunction

  function automatic int unsigned fall_level(int unsigned offset, int unsigned span);
    return peak_cfg - (offset * peak_cfg) / span;
  endfunction

  function automatic out_beat_t advance_lamp(in_beat_t beat);
    out_beat_t   res;
    sound_e      snd;
    int unsigned v;
    int unsigned t;
    int unsigned period;
    int unsigned half;
    int unsigned ph;
    snd = SND_NONE;
    if (beat.command_valid) begin
      if (beat.command_value == CMD_SAMPLE) begin
        latch_pattern({4'd0, beat.buttons}, 1'b0);
      end else begin
        latch_pattern(beat.command_value, 1'b1);
      end
    end
    latch_pattern({4'd0, beat.buttons}, 1'b0);
    if (entry_armed) begin
      entry_armed = 1'b0;
      case (cur_mode)
        MODE_BLINK: begin
          effect_t0  = beat.now_ms;
          steady_lit = !steady_lit;
          if (steady_lit) begin
            lamp_held = peak_cfg;
          end
          vib_held = 1'b0;
          snd      = SND_STOP;
        end
        MODE_OFF: begin
          steady_lit = 1'b0;
          lamp_held  = 0;
          vib_held   = 1'b0;
          snd        = SND_STOP;
        end
        MODE_BREATHE: begin
          steady_lit = 1'b0;
          effect_t0  = beat.now_ms;
          vib_held   = 1'b1;
          snd        = SND_PLAY;
        end
        default: begin
        end
      endcase
    end else if (cur_mode == MODE_BLINK) begin
      if (!steady_lit) begin
        v = beat.now_ms % 200;
        if (v <= 100) begin
          lamp_held = (v * peak_cfg) / 100;
        end else begin
          lamp_held = fall_level(v - 101, 99);
        end
      end
    end else if (cur_mode == MODE_BREATHE) begin
      t = beat.now_ms - effect_t0;
      if (t > 500) begin
        vib_held = 1'b1;
      end
      if (t < 10000) begin
        period = 1000 - (t * 800) / 10000;
        half   = period / 2;
        ph     = t % period;
        if (ph < half) begin
          lamp_held = (ph * peak_cfg) / half;
        end else begin
          lamp_held = fall_level(ph - half, period - half);
        end
      end else begin
        lamp_held = 0;
        vib_held  = 1'b0;
        snd       = SND_STOP;
      end
    end
    if (!player_cfg) begin
      snd = SND_NONE;
    end
    res.lamp_level    = lamp_held[7:0];
    res.vibration_on  = vib_held;
    res.sound_command = snd;
    res.active_mode   = cur_mode;
    return res;
  endfunction

  task automatic send_tick(input in_beat_t beat);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    lamp_expect_q.push_back(advance_lamp(beat));
  endtask

  task automatic tick(input logic [31:0] now, input logic [3:0] btn,
                      input logic cv = 1'b0, input logic [7:0] cval = 8'd0);
    in_beat_t beat;
    beat.now_ms        = now;
    beat.buttons       = btn;
    beat.command_valid = cv;
    beat.command_value = cval;
    send_tick(beat);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (lamp_expect_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_PEAK_LEVEL) begin
      peak_cfg = data;
    end else begin
      player_cfg = data[0];
    end
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (lamp_expect_q.size() == 0) begin
      $error("unexpected result beat %h", got);
      failures++;
      return;
    end
    want = lamp_expect_q.pop_front();
    if (got.lamp_level !== want.lamp_level) begin
      $error("lamp_level expected %0d actual %0d", want.lamp_level, got.lamp_level);
      failures++;
    end
    if (got.vibration_on !== want.vibration_on) begin
      $error("vibration_on expected %0d actual %0d", want.vibration_on, got.vibration_on);
      failures++;
    end
    if (got.sound_command !== want.sound_command) begin
      $error("sound_command expected %0d actual %0d", want.sound_command,
             got.sound_command);
      failures++;
    end
    if (got.active_mode !== want.active_mode) begin
      $error("active_mode expected %0d actual %0d", want.active_mode, got.active_mode);
      failures++;
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
    end
  end

  task automatic test_reset_state();
    tick(32'd0, 4'd0);
    tick(32'd150, 4'd0);
  endtask

  task automatic test_mode_entries();
    wait_results_drained();
    write_reg(REG_PEAK_LEVEL, 8'd255);
    write_reg(REG_PLAYER_PRESENT, 8'd1);
    tick(32'd1000, 4'd1);
    tick(32'd1000, 4'd1);
    tick(32'd1100, 4'd1);
    tick(32'd1101, 4'd1);
    tick(32'd1199, 4'd1);
    tick(32'd1300, 4'd2);
    tick(32'd1400, 4'd6);
    tick(32'd50000, 4'd4);
    tick(32'd50400, 4'd4);
    tick(32'd50600, 4'd4);
    tick(32'd55000, 4'd4);
    tick(32'd59999, 4'd4);
    tick(32'd60000, 4'd4);
    tick(32'd60010, 4'd4);
    tick(32'd60020, 4'd8);
    tick(32'd60030, 4'd8);
    tick(32'd60040, 4'd15);
  endtask

  task automatic test_special_cases();
    tick(32'd70000, 4'd1, 1'b1, 8'd1);
    tick(32'd70010, 4'd1, 1'b1, CMD_SAMPLE);
    tick(32'd70020, 4'd1, 1'b0, 8'hAB);
    tick(32'd70030, 4'd0, 1'b1, 8'h80);
    tick(32'hFFFF_F000, 4'd0, 1'b1, 8'd4);
    tick(32'h0000_0200, 4'd0);
    tick(32'hFFFF_FFFF, 4'd0);
    wait_results_drained();
    write_reg(REG_PLAYER_PRESENT, 8'd0);
    tick(32'd3000, 4'd2, 1'b1, 8'd4);
    tick(32'd3100, 4'd2);
  endtask

  task automatic test_random_traffic();
    in_beat_t    beat;
    logic [31:0] now;
    logic [3:0]  held;
    int unsigned pick;
    now  = $urandom;
    held = 4'd0;
    for (int phase = 0; phase < 7; phase++) begin
      wait_results_drained();
      case (phase)
        0: write_reg(REG_PEAK_LEVEL, 8'd255);
        1: write_reg(REG_PEAK_LEVEL, 8'd0);
        2: write_reg(REG_PEAK_LEVEL, 8'd1);
        default: write_reg(REG_PEAK_LEVEL, 8'($urandom_range(0, 255)));
      endcase
      write_reg(REG_PLAYER_PRESENT, (phase < 2) ? 8'(phase == 0) : 8'($urandom_range(0, 1)));
      for (int i = 0; i < 250; i++) begin
        if (i % 50 == 0) begin
          send_steady = ($urandom_range(0, 3) == 0);
          sink_steady = ($urandom_range(0, 3) == 0);
        end
        if (i == 125) begin
          wait_results_drained();
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          now = $urandom;
        end else if (pick == 1) begin
          now = now + $urandom_range(5000, 12000);
        end else begin
          now = now + $urandom_range(1, 250);
        end
        if ($urandom_range(0, 11) == 0) begin
          held = 4'($urandom_range(0, 15));
        end
        beat.now_ms        = now;
        beat.buttons       = held;
        beat.command_valid = 1'b0;
        beat.command_value = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
          0: begin
            beat.command_valid = 1'b1;
            beat.command_value = CMD_SAMPLE;
          end
          1: begin
            beat.command_valid = 1'b1;
            beat.command_value = 8'd1 << $urandom_range(0, 3);
          end
          2: beat.command_valid = 1'b1;
          3: begin
            beat.command_valid = 1'b1;
            beat.command_value = 8'h80;
          end
          default: begin
          end
        endcase
        send_tick(beat);
      end
    end
    send_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_PEAK_LEVEL;
    cfg_wdata_i = '0;
    model_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_mode_entries();
    test_special_cases();
    test_random_traffic();
    wait_results_drained();
    if (failures == 0) begin
      $display("lamp_effect_mode_sequencer verification clean");
    end else begin
      $display("lamp_effect_mode_sequencer verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("lamp_effect_mode_sequencer verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lemsq_pkg.sv
hdl/lemsq_div.sv
hdl/lemsq_ctrl.sv
hdl/lemsq_dp.sv
hdl/lamp_effect_mode_sequencer.sv
tb/tb_top.sv
